// ===== src/delta_instruction_decoder_assert.svh =====
// assertion macros for the delta instruction decoder
`ifndef DELTA_INSTRUCTION_DECODER_ASSERT_SVH
`define DELTA_INSTRUCTION_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
`define DID_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("delta decoder check failed");
`define DID_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("delta decoder check failed");
`else
`define DID_ASSERT_NOW(label, cond, expr)
`define DID_ASSERT_NEXT(label, cond, expr)
`endif

`endif

// ===== src/did_pkg.sv =====
// types and constants shared by the delta instruction decoder files
package did_pkg;

    typedef enum logic [1:0] {
        KIND_COPY    = 2'd0,
        KIND_LITERAL = 2'd1,
        KIND_END     = 2'd2,
        KIND_TRUNC   = 2'd3
    } kind_t;

    typedef enum logic [4:0] {
        PH_HDR1   = 5'b00001,
        PH_HDR2   = 5'b00010,
        PH_OPCODE = 5'b00100,
        PH_COPY   = 5'b01000,
        PH_LIT    = 5'b10000
    } phase_t;

    localparam logic [23:0] COPY_DEFAULT_LEN = 24'h010000;

    typedef struct packed {
        logic [7:0] delta_byte;
        logic       final_byte;
    } did_in_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] base_offset;
        logic [23:0] copy_length;
        logic [7:0]  literal_byte;
        logic        stream_done;
    } did_out_t;

    typedef struct packed {
        logic     valid;
        did_out_t item;
    } did_res_t;

endpackage

// ===== src/did_step.sv =====
// parse state and per-byte decode of the delta stream
module did_step
    import did_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step_en,
    input  did_in_t  item,
    output did_res_t res
);

    phase_t      phase_reg,   phase_next;
    logic [6:0]  pending_reg, pending_next;
    logic [31:0] offset_reg,  offset_next;
    logic [23:0] size_reg,    size_next;
    logic [6:0]  lits_reg,    lits_next;

    logic [7:0]  b;
    logic [6:0]  sel;
    logic [31:0] off_mask;
    logic [23:0] size_mask;
    logic        have;
    logic        boundary;
    did_out_t    copy_item;

    assign b         = item.delta_byte;
    assign sel       = pending_reg & (~pending_reg + 7'd1);
    assign off_mask  = {{8{sel[3]}}, {8{sel[2]}}, {8{sel[1]}}, {8{sel[0]}}};
    assign size_mask = {{8{sel[6]}}, {8{sel[5]}}, {8{sel[4]}}};

    always_comb
    begin
        phase_next   = phase_reg;
        pending_next = pending_reg;
        offset_next  = offset_reg;
        size_next    = size_reg;
        lits_next    = lits_reg;
        have         = 1'b0;
        boundary     = 1'b0;
        res          = '0;
        copy_item    = '0;

        case (phase_reg)
            PH_HDR1:
            begin
                if (!b[7])
                begin
                    phase_next = PH_HDR2;
                end
            end
            PH_HDR2:
            begin
                if (!b[7])
                begin
                    phase_next = PH_OPCODE;
                    boundary   = 1'b1;
                end
            end
            PH_COPY:
            begin
                offset_next  = offset_reg | ({4{b}} & off_mask);
                size_next    = size_reg | ({3{b}} & size_mask);
                pending_next = pending_reg & ~sel;
                if (pending_next == 7'd0)
                begin
                    have       = 1'b1;
                    boundary   = 1'b1;
                    phase_next = PH_OPCODE;
                end
            end
            PH_LIT:
            begin
                if (lits_reg != 7'd0)
                begin
                    have                = 1'b1;
                    res.item.kind       = KIND_LITERAL;
                    res.item.literal_byte = b;
                    lits_next           = lits_reg - 7'd1;
                end
                if (lits_next == 7'd0)
                begin
                    phase_next = PH_OPCODE;
                    boundary   = 1'b1;
                end
            end
            default:
            begin
                if (b[7])
                begin
                    pending_next = b[6:0];
                    offset_next  = '0;
                    size_next    = '0;
                    if (b[6:0] == 7'd0)
                    begin
                        have       = 1'b1;
                        boundary   = 1'b1;
                        phase_next = PH_OPCODE;
                    end
                    else
                    begin
                        phase_next = PH_COPY;
                    end
                end
                else if (b == 8'd0)
                begin
                    phase_next = PH_OPCODE;
                    boundary   = 1'b1;
                end
                else
                begin
                    lits_next  = b[6:0];
                    phase_next = PH_LIT;
                end
            end
        endcase

        // copy command built from the updated accumulators
        copy_item.kind        = KIND_COPY;
        copy_item.base_offset = offset_next;
        copy_item.copy_length = (size_next == 24'd0) ? COPY_DEFAULT_LEN : size_next;
        if (have && (res.item.kind != KIND_LITERAL))
        begin
            res.item = copy_item;
        end

        res.valid = have;
        if (item.final_byte)
        begin
            res.valid = 1'b1;
            if (!boundary)
            begin
                res.item      = '0;
                res.item.kind = KIND_TRUNC;
            end
            else if (!have)
            begin
                res.item      = '0;
                res.item.kind = KIND_END;
            end
            res.item.stream_done = 1'b1;
            phase_next   = PH_HDR1;
            pending_next = '0;
            offset_next  = '0;
            size_next    = '0;
            lits_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HDR1;
            pending_reg <= '0;
            offset_reg  <= '0;
            size_reg    <= '0;
            lits_reg    <= '0;
        end
        else if (step_en)
        begin
            phase_reg   <= phase_next;
            pending_reg <= pending_next;
            offset_reg  <= offset_next;
            size_reg    <= size_next;
            lits_reg    <= lits_next;
        end
    end

endmodule

// ===== src/delta_instruction_decoder.sv =====
// top level of the delta instruction decoder
//
// delta channel: one byte of a delta stream per item, final_byte marks the
// last byte of the stream. cmd channel: zero or one result per byte: a copy
// command, a literal byte, an end marker or a truncated-instruction error;
// stream_done is set on the result that closes the stream.
// an accepted byte is held in the input register and is decoded from there
// into the result register once the result register is free or its result
// is taken. one byte per cycle is taken at full rate, while cmd_stall does not
// hold a waiting result; the single decode pass per byte sets that figure.
// reset clears both valid flags and returns the parser to the first size header.
// while cmd_stall holds a waiting result, the input register still takes one
// more byte; after that delta_stall rises until the result is taken.
`include "delta_instruction_decoder_assert.svh"

module delta_instruction_decoder
    import did_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     delta_valid,
    output logic     delta_stall,
    input  did_in_t  delta_data,
    output logic     cmd_valid,
    input  logic     cmd_stall,
    output did_out_t cmd_data
);

    logic     s1_valid_reg, s1_valid_next;
    did_in_t  s1_item_reg;
    logic     out_valid_reg, out_valid_next;
    did_out_t out_item_reg;
    logic     s1_adv;
    logic     in_acc;
    did_res_t res;
    logic     out_closes;
    logic     out_is_copy;

    assign s1_adv      = s1_valid_reg && (!out_valid_reg || !cmd_stall);
    assign delta_stall = s1_valid_reg && !s1_adv;
    assign in_acc      = delta_valid && !delta_stall;

    did_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (s1_adv),
        .item    (s1_item_reg),
        .res     (res)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = res.valid;
        end
        else if (out_valid_reg && !cmd_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_item_reg <= delta_data;
        end
        if (s1_adv && res.valid)
        begin
            out_item_reg <= res.item;
        end
    end

    assign cmd_valid = out_valid_reg;
    assign cmd_data  = out_item_reg;

    assign out_closes  = out_valid_reg &&
                         (out_item_reg.kind == KIND_END || out_item_reg.kind == KIND_TRUNC);
    assign out_is_copy = out_valid_reg && (out_item_reg.kind == KIND_COPY);

    // a final byte always yields a result
    `DID_ASSERT_NOW(a_final_gives_result, s1_adv && s1_item_reg.final_byte, res.valid)
    // end marker and error always close a stream
    `DID_ASSERT_NOW(a_end_closes, out_closes, out_item_reg.stream_done)
    // copy length never zero
    `DID_ASSERT_NOW(a_copy_len, out_is_copy, out_item_reg.copy_length != 24'd0)
    // a held byte is not lost
    `DID_ASSERT_NEXT(a_s1_held, s1_valid_reg && !s1_adv, s1_valid_reg && $stable(s1_item_reg))

endmodule
